/* src/ring_aware_inductive_steering_unit_assert.svh */
// Assertion macros for the ring-aware inductive steering unit checker.
// Each macro expects signals named clk and arst_n in the scope where it is used.
`ifndef RING_AWARE_INDUCTIVE_STEERING_UNIT_ASSERT_SVH
`define RING_AWARE_INDUCTIVE_STEERING_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RAIS_ASSERT_IMPLY(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define RAIS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* src/rais_pkg.sv */
// Shared widths, constants and types of the ring-aware inductive steering unit.
// No dependencies; the interfaces, the unit and the checker import this package.
`timescale 1ns / 1ps

package rais_pkg;

	localparam int SAMPLE_BITS = 8;
	localparam int SUM_W       = SAMPLE_BITS + 2;
	localparam int THR_W       = 10;
	localparam int CMP_W       = (SUM_W > THR_W) ? SUM_W : THR_W;
	localparam int DIFF_W      = SAMPLE_BITS + 1;
	localparam int MIX_W       = SAMPLE_BITS + 5;
	localparam int QUO_W       = 15;
	localparam int NUM_W       = MIX_W + QUO_W;
	localparam int ERR_W       = 16;
	localparam int DERR_W      = ERR_W + 1;
	localparam int GAIN_W      = 16;
	localparam int ACC_W       = 35;
	localparam int FRAC_SHIFT  = 16;
	localparam int DRV_W       = 16;
	localparam int CNT_W       = 8;
	localparam int BEEP_W      = 6;
	localparam int MUL_STEPS   = DERR_W;
	localparam int STEP_W      = $clog2(MUL_STEPS);

	localparam int REG_IDX_W   = 3;
	localparam int CFG_AW      = REG_IDX_W + 2;
	localparam int CFG_DW      = 32;

	localparam int LEFT_DIFF       = 30;
	localparam int RIGHT_DIFF      = 20;
	localparam int SIDE_MIN        = 90;
	localparam int TIMEOUT_LOAD    = 120;
	localparam int ENTRY_HOLD_LOAD = 80;
	localparam int EXIT_HOLD_LOAD  = 100;
	localparam int BEEP_CROSS      = 10;
	localparam int BEEP_ENTRY      = 20;
	localparam int BEEP_EXIT       = 60;

	// Mix weights at 20 times their value: 0.25, 0.5, 0.7, 0.75.
	localparam int MIX_QUARTER  = 5;
	localparam int MIX_HALF     = 10;
	localparam int MIX_SEVENTH  = 14;
	localparam int MIX_THREEQ   = 15;

	// 100 times 256: percent scale with 8 fraction bits.
	localparam int ERR_SCALE    = 25600;

	localparam int RST_SUM_THRESHOLD = 330;
	localparam int RST_ENTRY_CONFIRM = 7;
	localparam int RST_EXIT_CONFIRM  = 10;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_PROP_GAIN     = 3'd0,
		REG_DERIV_GAIN    = 3'd1,
		REG_SUM_THRESHOLD = 3'd2,
		REG_ENTRY_CONFIRM = 3'd3,
		REG_EXIT_CONFIRM  = 3'd4
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PREP,
		ST_DIV,
		ST_EVAL,
		ST_MUL,
		ST_DONE
	} state_t;

endpackage

/* src/rais_if.sv */
// Valid/ready channel interfaces for sensor ticks and steering results.
// Depends on rais_pkg for the field widths.
`timescale 1ns / 1ps

interface rais_in_if import rais_pkg::*; ();
	logic                   valid;
	logic                   ready;
	logic [SAMPLE_BITS-1:0] sample_a;
	logic [SAMPLE_BITS-1:0] sample_b;
	logic [SAMPLE_BITS-1:0] sample_c;
	logic [SAMPLE_BITS-1:0] sample_d;
	logic                   crossing_seen;

	modport source (output valid, sample_a, sample_b, sample_c, sample_d, crossing_seen,
		input ready);
	modport sink (input valid, sample_a, sample_b, sample_c, sample_d, crossing_seen,
		output ready);
endinterface

interface rais_out_if import rais_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic signed [DRV_W-1:0] steer_drive;
	logic signed [ERR_W-1:0] norm_error;
	logic                    left_ring;
	logic                    right_ring;
	logic                    beep_load;
	logic [BEEP_W-1:0]       beep_ticks;
	logic                    zero_sum;

	modport source (output valid, steer_drive, norm_error, left_ring, right_ring, beep_load,
		beep_ticks, zero_sum, input ready);
	modport sink (input valid, steer_drive, norm_error, left_ring, right_ring, beep_load,
		beep_ticks, zero_sum, output ready);
endinterface

/* src/ring_aware_inductive_steering_unit.sv */
// Ring-aware inductive steering unit: ring state tracking, normalized error, PD drive.
// A new tick is taken only after the last one has left the bit-serial divider (15
// quotient bits, one per cycle) and the bit-serial PD multiplier (17 multiplier bits)
// and its result has been loaded into the output register.
// Reset (arst_n, asynchronous, active low) clears all ring state and the previous
// error and loads the register defaults; no clearing pass is needed.
`timescale 1ns / 1ps

module ring_aware_inductive_steering_unit import rais_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	rais_in_if.sink            sensor,
	rais_out_if.source         steer,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [CFG_AW-1:0]  paddr,
	input  logic [CFG_DW-1:0]  pwdata,
	output logic [CFG_DW-1:0]  prdata,
	output logic               pready
);

	// ------------------------------------------------------------------
	// Configuration registers. The APB access phase never waits, so
	// pready is tied high. Writes past the last register are
	// dropped and read back as zero.
	// ------------------------------------------------------------------
	logic signed [GAIN_W-1:0] prop_gain_q;
	logic signed [GAIN_W-1:0] deriv_gain_q;
	logic [THR_W-1:0]         sum_threshold_q;
	logic [CNT_W-1:0]         entry_confirm_q;
	logic [CNT_W-1:0]         exit_confirm_q;
	logic                     cfg_wr;
	reg_idx_t                 cfg_idx;

	assign pready  = 1'b1;
	assign cfg_idx = reg_idx_t'(paddr[CFG_AW-1:2]);
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prop_gain_q     <= '0;
			deriv_gain_q    <= '0;
			sum_threshold_q <= THR_W'(RST_SUM_THRESHOLD);
			entry_confirm_q <= CNT_W'(RST_ENTRY_CONFIRM);
			exit_confirm_q  <= CNT_W'(RST_EXIT_CONFIRM);
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				REG_PROP_GAIN:     prop_gain_q     <= pwdata[GAIN_W-1:0];
				REG_DERIV_GAIN:    deriv_gain_q    <= pwdata[GAIN_W-1:0];
				REG_SUM_THRESHOLD: sum_threshold_q <= pwdata[THR_W-1:0];
				REG_ENTRY_CONFIRM: entry_confirm_q <= pwdata[CNT_W-1:0];
				REG_EXIT_CONFIRM:  exit_confirm_q  <= pwdata[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (cfg_idx)
			REG_PROP_GAIN:     prdata = {{(CFG_DW-GAIN_W){1'b0}}, prop_gain_q};
			REG_DERIV_GAIN:    prdata = {{(CFG_DW-GAIN_W){1'b0}}, deriv_gain_q};
			REG_SUM_THRESHOLD: prdata = {{(CFG_DW-THR_W){1'b0}}, sum_threshold_q};
			REG_ENTRY_CONFIRM: prdata = {{(CFG_DW-CNT_W){1'b0}}, entry_confirm_q};
			REG_EXIT_CONFIRM:  prdata = {{(CFG_DW-CNT_W){1'b0}}, exit_confirm_q};
			default:           prdata = '0;
		endcase
	end

	// ------------------------------------------------------------------
	// Sequencer. A tick is taken only in IDLE. PREP forms the divider
	// operands, DIV produces one quotient bit per cycle, EVAL signs the
	// quotient and loads the multiplier, MUL adds one partial product per
	// cycle and DONE rounds, saturates and hands the result to the output
	// register as soon as that register is free.
	// ------------------------------------------------------------------
	state_t            state_q;
	state_t            state_d;
	logic [STEP_W-1:0] step_q;
	logic              in_ready;
	logic              tick_take;
	logic              out_free;
	logic              out_load;
	logic              out_valid_q;

	assign out_free = !out_valid_q || steer.ready;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (sensor.valid) state_d = ST_PREP;
			ST_PREP: state_d = ST_DIV;
			ST_DIV:  if (step_q == '0) state_d = ST_EVAL;
			ST_EVAL: state_d = ST_MUL;
			ST_MUL:  if (step_q == '0) state_d = ST_DONE;
			ST_DONE: if (out_free) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		out_load = 1'b0;
		unique case (state_q)
			ST_IDLE: in_ready = 1'b1;
			ST_DONE: out_load = out_free;
			default: ;
		endcase
	end

	assign sensor.ready = in_ready;
	assign tick_take    = in_ready && sensor.valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
		end else begin
			state_q <= state_d;
			case (state_q)
				ST_PREP: step_q <= STEP_W'(QUO_W - 1);
				ST_EVAL: step_q <= STEP_W'(MUL_STEPS - 1);
				ST_DIV, ST_MUL: step_q <= step_q - STEP_W'(1);
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Ring state update, done in the cycle the tick is transferred in.
	// Holdoffs and the timeout count down first; an expiring timeout
	// drops both ring flags before entry and exit are judged.
	// ------------------------------------------------------------------
	logic [CNT_W-1:0] entry_cnt_q, entry_cnt_d;
	logic [CNT_W-1:0] exit_cnt_q, exit_cnt_d;
	logic [CNT_W-1:0] entry_hold_q, entry_hold_d;
	logic [CNT_W-1:0] exit_hold_q, exit_hold_d;
	logic [CNT_W-1:0] ring_to_q, ring_to_d;
	logic             left_q, left_d;
	logic             right_q, right_d;
	logic [MIX_W-1:0] lmix_q, lmix_d;
	logic [MIX_W-1:0] rmix_q, rmix_d;
	logic             beep_d;
	logic [BEEP_W-1:0] blen_d;

	logic [SUM_W-1:0]         side_sum;
	logic                     sum_high;
	logic signed [DIFF_W-1:0] diff_ad;
	logic signed [DIFF_W-1:0] diff_da;
	logic                     left_asym;
	logic                     right_asym;
	logic [CNT_W-1:0]         entry_cnt_inc;
	logic [CNT_W-1:0]         exit_cnt_inc;
	logic [MIX_W-1:0]         mix_a, mix_b, mix_c, mix_d;

	assign mix_a = MIX_W'(sensor.sample_a);
	assign mix_b = MIX_W'(sensor.sample_b);
	assign mix_c = MIX_W'(sensor.sample_c);
	assign mix_d = MIX_W'(sensor.sample_d);

	assign side_sum = SUM_W'(sensor.sample_a) + SUM_W'(sensor.sample_b)
		+ SUM_W'(sensor.sample_c) + SUM_W'(sensor.sample_d);
	assign diff_ad = $signed({1'b0, sensor.sample_a}) - $signed({1'b0, sensor.sample_d});
	assign diff_da = $signed({1'b0, sensor.sample_d}) - $signed({1'b0, sensor.sample_a});
	assign left_asym = (diff_ad > $signed(DIFF_W'(LEFT_DIFF)))
		&& (sensor.sample_a > SAMPLE_BITS'(SIDE_MIN));
	assign right_asym = (diff_da > $signed(DIFF_W'(RIGHT_DIFF)))
		&& (sensor.sample_d > SAMPLE_BITS'(SIDE_MIN));
	assign entry_cnt_inc = entry_cnt_q + CNT_W'(1);
	assign exit_cnt_inc  = exit_cnt_q + CNT_W'(1);

	always_comb begin
		exit_hold_d  = (exit_hold_q != '0) ? exit_hold_q - CNT_W'(1) : exit_hold_q;
		entry_hold_d = (entry_hold_q != '0) ? entry_hold_q - CNT_W'(1) : entry_hold_q;
		ring_to_d    = ring_to_q;
		left_d       = left_q;
		right_d      = right_q;
		if (ring_to_q != '0) begin
			ring_to_d = ring_to_q - CNT_W'(1);
			if (ring_to_d == '0) begin
				left_d  = 1'b0;
				right_d = 1'b0;
			end
		end
		entry_cnt_d = entry_cnt_q;
		exit_cnt_d  = exit_cnt_q;
		lmix_d      = lmix_q;
		rmix_d      = rmix_q;
		beep_d      = sensor.crossing_seen;
		blen_d      = sensor.crossing_seen ? BEEP_W'(BEEP_CROSS) : '0;

		sum_high = (CMP_W'(side_sum) > CMP_W'(sum_threshold_q))
			&& (exit_hold_d == '0) && (entry_hold_d == '0);

		if (sum_high) begin
			if (!left_d && !right_d) begin
				entry_cnt_d = entry_cnt_inc;
				if (left_asym) begin
					if (entry_cnt_inc >= entry_confirm_q) begin
						left_d       = 1'b1;
						entry_cnt_d  = '0;
						beep_d       = 1'b1;
						blen_d       = BEEP_W'(BEEP_ENTRY);
						ring_to_d    = CNT_W'(TIMEOUT_LOAD);
						entry_hold_d = CNT_W'(ENTRY_HOLD_LOAD);
					end
				end else if (right_asym) begin
					if (entry_cnt_inc >= entry_confirm_q) begin
						right_d      = 1'b1;
						entry_cnt_d  = '0;
						beep_d       = 1'b1;
						blen_d       = BEEP_W'(BEEP_ENTRY);
						ring_to_d    = CNT_W'(TIMEOUT_LOAD);
						entry_hold_d = CNT_W'(ENTRY_HOLD_LOAD);
					end
				end else begin
					lmix_d = mix_a * MIX_W'(MIX_QUARTER) + mix_b * MIX_W'(MIX_THREEQ);
					rmix_d = mix_c * MIX_W'(MIX_THREEQ) + mix_d * MIX_W'(MIX_QUARTER);
				end
			end else begin
				// Inside a ring: the left flag wins when both are set.
				exit_cnt_d = exit_cnt_inc;
				if (exit_cnt_inc >= exit_confirm_q) begin
					if (left_d) begin
						left_d = 1'b0;
						lmix_d = mix_a * MIX_W'(MIX_HALF) + mix_b * MIX_W'(MIX_QUARTER);
						rmix_d = mix_c * MIX_W'(MIX_SEVENTH) + mix_d * MIX_W'(MIX_SEVENTH);
					end else begin
						right_d = 1'b0;
						lmix_d  = mix_a * MIX_W'(MIX_SEVENTH) + mix_b * MIX_W'(MIX_SEVENTH);
						rmix_d  = mix_c * MIX_W'(MIX_HALF) + mix_d * MIX_W'(MIX_QUARTER);
					end
					exit_cnt_d  = '0;
					beep_d      = 1'b1;
					blen_d      = BEEP_W'(BEEP_EXIT);
					exit_hold_d = CNT_W'(EXIT_HOLD_LOAD);
				end
			end
		end else if (left_d) begin
			lmix_d = mix_a * MIX_W'(MIX_HALF) + mix_b * MIX_W'(MIX_HALF);
			rmix_d = mix_c * MIX_W'(MIX_HALF);
		end else if (right_d) begin
			lmix_d = mix_b * MIX_W'(MIX_HALF);
			rmix_d = mix_c * MIX_W'(MIX_HALF) + mix_d * MIX_W'(MIX_HALF);
		end else begin
			entry_cnt_d = '0;
			exit_cnt_d  = '0;
			lmix_d = mix_a * MIX_W'(MIX_QUARTER) + mix_b * MIX_W'(MIX_THREEQ);
			rmix_d = mix_c * MIX_W'(MIX_THREEQ) + mix_d * MIX_W'(MIX_QUARTER);
		end
	end

	// ------------------------------------------------------------------
	// Divider operands. The error is sign(L-R) * floor(|L-R|*25600 / S),
	// which matches truncation toward zero. |L-R| never exceeds S, so the
	// quotient fits in 15 bits and 15 restoring steps suffice.
	// ------------------------------------------------------------------
	logic [MIX_W:0]        div_sum;
	logic signed [MIX_W:0] div_diff;
	logic [MIX_W:0]        div_abs;
	logic [NUM_W-1:0]      div_num;
	logic [NUM_W-1:0]      rem_q;
	logic [NUM_W-1:0]      dsh_q;
	logic [QUO_W-1:0]      quo_q;
	logic                  neg_q;
	logic                  zero_q;
	logic                  div_ge;

	assign div_sum  = {1'b0, lmix_q} + {1'b0, rmix_q};
	assign div_diff = $signed({1'b0, lmix_q}) - $signed({1'b0, rmix_q});
	assign div_abs  = div_diff[MIX_W] ? -div_diff : div_diff;
	assign div_num  = NUM_W'(div_abs[MIX_W-1:0]) * NUM_W'(ERR_SCALE);
	assign div_ge   = rem_q >= dsh_q;

	// ------------------------------------------------------------------
	// PD drive: prop_gain*e + deriv_gain*(e - prev), one bit of e and of
	// the difference per cycle. The last bit is the two's complement sign
	// and is subtracted.
	// ------------------------------------------------------------------
	logic signed [ERR_W-1:0]  prev_err_q;
	logic signed [ERR_W-1:0]  err_v;
	logic [ERR_W-1:0]         quo_ext;
	logic signed [DERR_W-1:0] derr_v;
	logic [DERR_W-1:0]        mp_q;
	logic [DERR_W-1:0]        md_q;
	logic [ACC_W-1:0]         ap_q;
	logic [ACC_W-1:0]         ad_q;
	logic [ACC_W-1:0]         acc_q;
	logic [ACC_W-1:0]         mul_term;
	logic [ACC_W-1:0]         acc_step;

	assign quo_ext = {1'b0, quo_q};
	assign err_v   = zero_q ? '0 : (neg_q ? -$signed(quo_ext) : $signed(quo_ext));
	assign derr_v  = $signed({err_v[ERR_W-1], err_v}) - $signed({prev_err_q[ERR_W-1], prev_err_q});
	assign mul_term = (mp_q[0] ? ap_q : '0) + (md_q[0] ? ad_q : '0);
	assign acc_step = (step_q == '0) ? acc_q - mul_term : acc_q + mul_term;

	// Divide by 2^16 toward zero, then clamp to the int16 range.
	localparam int TRQ_W = ACC_W - FRAC_SHIFT;
	localparam logic signed [TRQ_W-1:0] DRV_HI = TRQ_W'((1 << (DRV_W - 1)) - 1);
	localparam logic signed [TRQ_W-1:0] DRV_LO = -TRQ_W'(1 << (DRV_W - 1));

	logic signed [TRQ_W-1:0] drv_trunc;
	logic signed [DRV_W-1:0] drv_sat;
	logic                    drv_round;

	assign drv_round = acc_q[ACC_W-1] && (acc_q[FRAC_SHIFT-1:0] != '0);
	assign drv_trunc = $signed(acc_q[ACC_W-1:FRAC_SHIFT]) + $signed({{(TRQ_W-1){1'b0}}, drv_round});

	always_comb begin
		if (drv_trunc > DRV_HI) begin
			drv_sat = DRV_HI[DRV_W-1:0];
		end else if (drv_trunc < DRV_LO) begin
			drv_sat = DRV_LO[DRV_W-1:0];
		end else begin
			drv_sat = drv_trunc[DRV_W-1:0];
		end
	end

	// Ring state and previous error: architectural, cleared by reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_cnt_q  <= '0;
			exit_cnt_q   <= '0;
			entry_hold_q <= '0;
			exit_hold_q  <= '0;
			ring_to_q    <= '0;
			left_q       <= 1'b0;
			right_q      <= 1'b0;
			lmix_q       <= '0;
			rmix_q       <= '0;
			prev_err_q   <= '0;
		end else begin
			if (tick_take) begin
				entry_cnt_q  <= entry_cnt_d;
				exit_cnt_q   <= exit_cnt_d;
				entry_hold_q <= entry_hold_d;
				exit_hold_q  <= exit_hold_d;
				ring_to_q    <= ring_to_d;
				left_q       <= left_d;
				right_q      <= right_d;
				lmix_q       <= lmix_d;
				rmix_q       <= rmix_d;
			end
			if (state_q == ST_EVAL) begin
				prev_err_q <= err_v;
			end
		end
	end

	// Per-tick result fields, held until the output register takes them.
	logic              st_beep_q;
	logic [BEEP_W-1:0] st_blen_q;
	logic signed [ERR_W-1:0] err_q;

	always_ff @(posedge clk) begin
		if (tick_take) begin
			st_beep_q <= beep_d;
			st_blen_q <= blen_d;
		end
		case (state_q)
			ST_PREP: begin
				rem_q  <= div_num;
				dsh_q  <= NUM_W'(div_sum) << (QUO_W - 1);
				quo_q  <= '0;
				neg_q  <= div_diff[MIX_W];
				zero_q <= (div_sum == '0);
			end
			ST_DIV: begin
				if (div_ge) begin
					rem_q <= rem_q - dsh_q;
				end
				dsh_q <= dsh_q >> 1;
				quo_q <= {quo_q[QUO_W-2:0], div_ge};
			end
			ST_EVAL: begin
				err_q <= err_v;
				mp_q  <= {err_v[ERR_W-1], err_v};
				md_q  <= derr_v;
				ap_q  <= {{(ACC_W-GAIN_W){prop_gain_q[GAIN_W-1]}}, prop_gain_q};
				ad_q  <= {{(ACC_W-GAIN_W){deriv_gain_q[GAIN_W-1]}}, deriv_gain_q};
				acc_q <= '0;
			end
			ST_MUL: begin
				acc_q <= acc_step;
				ap_q  <= ap_q << 1;
				ad_q  <= ad_q << 1;
				mp_q  <= mp_q >> 1;
				md_q  <= md_q >> 1;
			end
			default: ;
		endcase
	end

	// ------------------------------------------------------------------
	// Output register. It decouples the result from the datapath, so the
	// next tick is taken while this result still waits for its transfer.
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (steer.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			steer.steer_drive <= drv_sat;
			steer.norm_error  <= err_q;
			steer.left_ring   <= left_q;
			steer.right_ring  <= right_q;
			steer.beep_load   <= st_beep_q;
			steer.beep_ticks  <= st_blen_q;
			steer.zero_sum    <= zero_q;
		end
	end

	assign steer.valid = out_valid_q;

endmodule

/* src/rais_checker.sv */
// Port-level checker for the ring-aware inductive steering unit, with its bind.
// Depends on rais_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "ring_aware_inductive_steering_unit_assert.svh"

module rais_checker import rais_pkg::*; (
	input logic                    clk,
	input logic                    arst_n,
	input logic                    in_valid,
	input logic                    in_ready,
	input logic                    out_valid,
	input logic                    out_ready,
	input logic signed [ERR_W-1:0] norm_error,
	input logic                    left_ring,
	input logic                    right_ring,
	input logic                    beep_load,
	input logic [BEEP_W-1:0]       beep_ticks
);

	// A shown result stays until its transfer.
	`RAIS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped while stalled")

	// Ticks are worked one at a time, so a transfer in closes the input.
	`RAIS_ASSERT_NEXT(a_in_busy, in_valid && in_ready, !in_ready, "tick taken while busy")

	// Entry needs both flags clear and exit clears one, so they never coexist.
	`RAIS_ASSERT_IMPLY(a_one_ring, out_valid, !(left_ring && right_ring), "both ring flags set")

	`RAIS_ASSERT_IMPLY(a_beep_code, out_valid, (beep_load ? (beep_ticks == BEEP_W'(BEEP_CROSS) || beep_ticks == BEEP_W'(BEEP_ENTRY) || beep_ticks == BEEP_W'(BEEP_EXIT)) : (beep_ticks == '0)), "bad beeper duration")

	`RAIS_ASSERT_IMPLY(a_err_range, out_valid, (norm_error <= 16'sd25600 && norm_error >= -16'sd25600), "error out of range")

endmodule

bind ring_aware_inductive_steering_unit rais_checker u_rais_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (sensor.valid),
	.in_ready   (sensor.ready),
	.out_valid  (steer.valid),
	.out_ready  (steer.ready),
	.norm_error (steer.norm_error),
	.left_ring  (steer.left_ring),
	.right_ring (steer.right_ring),
	.beep_load  (steer.beep_load),
	.beep_ticks (steer.beep_ticks)
);
